// ===== rtl/core/rprm_pkg.sv =====
// shared constants of the radiation pulse rate meter
package rprm_pkg;

   // field widths
   localparam int unsigned FUNC_W   = 2;
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned FACTOR_W = 24;
   localparam int unsigned COUNT_W  = 24;
   localparam int unsigned MEAN_W   = 40;
   localparam int unsigned ROLL_W   = 27;
   localparam int unsigned CPM_W    = 32;
   localparam int unsigned DOSE_W   = 32;

   // item function codes
   localparam logic [FUNC_W-1:0] FUNC_PULSE  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_REPORT = 2'd2;

   // register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOSE_FACTOR = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_USE_ROLLING = 2'd1;
   localparam logic [FACTOR_W-1:0]    DOSE_FACTOR_RESET = 24'd92107;

   // shared restoring divider
   localparam int unsigned DIV_W  = 44;
   localparam int unsigned RATE_W = 34;
   localparam int unsigned STEP_W = 6;
   // 60e6 per minute in q32.8
   localparam logic [RATE_W-1:0] RATE_NUM     = 34'd15360000000;
   localparam logic [MEAN_W-1:0] MEAN_DIVISOR = 40'd10;
   localparam logic [7:0]        MEAN_ROUND   = 8'd5;
   localparam logic [STEP_W-1:0] DIV_STEPS_MEAN = 6'd44;
   localparam logic [STEP_W-1:0] DIV_STEPS_RATE = 6'd34;

   // shift-add multiplier
   localparam int unsigned MUL_W  = 32;
   localparam int unsigned PROD_W = FACTOR_W + MUL_W;
   localparam logic [STEP_W-1:0] MUL_STEPS = 6'd32;

endpackage

// ===== rtl/core/radiation_pulse_rate_meter_unit.sv =====
// radiation pulse rate meter: bin counting, interval average, rate and dose report
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_func, req_timestamp
//   rsp     | out       | rsp_valid/rsp_stall  | rolling, instant cpm/valid, dose
//   csr     | in        | csr_write            | csr_index, csr_data
//
// a tick, an unknown code or a first/second pulse is finished in S_IDLE
// later pulses pass S_MEAN9 and S_MEANADD to form 9*mean+x+5, then the bit-serial divide by 10
// a report runs the rate divide (skipped if no mean), then the multiply: 34 divider steps, 32 multiplier steps
// one item at a time; the finished report waits in the output register so
// further items are taken while rsp is stalled
// reset is synchronous and clears all control state and the bin store
module radiation_pulse_rate_meter_unit #(
   parameter int unsigned NUM_BINS = 6
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [rprm_pkg::FUNC_W-1:0]          req_func,
   input  logic [rprm_pkg::TIME_W-1:0]          req_timestamp,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [rprm_pkg::ROLL_W-1:0]          rsp_rolling_cpm,
   output logic [rprm_pkg::CPM_W-1:0]           rsp_instant_cpm,
   output logic                                 rsp_instant_valid,
   output logic [rprm_pkg::DOSE_W-1:0]          rsp_dose_rate,
   input  logic                                 csr_write,
   input  logic [rprm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rprm_pkg::FACTOR_W-1:0]        csr_data
);

   localparam int unsigned SLOT_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int unsigned SUM_W  = rprm_pkg::COUNT_W + SLOT_W;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_BINS - 1);
   localparam logic [rprm_pkg::MUL_W-1:0] ROLL_MAX = (32'd1 << rprm_pkg::ROLL_W) - 32'd1;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_MEAN9   = 7'b0000010,
      S_MEANADD = 7'b0000100,
      S_DIV     = 7'b0001000,
      S_MLOAD   = 7'b0010000,
      S_MUL     = 7'b0100000,
      S_OUT     = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [rprm_pkg::FACTOR_W-1:0] dose_factor_ff;
   logic                          use_rolling_ff;

   logic [rprm_pkg::TIME_W-1:0]  last_time_ff, last_time_in;
   logic                         seen_pulse_ff, seen_pulse_in;
   logic [rprm_pkg::TIME_W-1:0]  interval_ff, interval_in;
   logic [rprm_pkg::MEAN_W-1:0]  mean_ff, mean_in;
   logic                         mean_valid_ff, mean_valid_in;
   logic [rprm_pkg::COUNT_W-1:0] pending_ff, pending_in;
   logic [rprm_pkg::COUNT_W-1:0] bins_ff [NUM_BINS];
   logic [SLOT_W-1:0]            slot_ff, slot_in;
   logic [SUM_W-1:0]             window_sum_ff, window_sum_in;

   logic [rprm_pkg::DIV_W-1:0]   div_q_ff, div_q_in;
   logic [rprm_pkg::MEAN_W-1:0]  div_rem_ff, div_rem_in;
   logic [rprm_pkg::MEAN_W-1:0]  div_den_ff, div_den_in;
   logic                         div_rate_ff, div_rate_in;
   logic [rprm_pkg::STEP_W-1:0]  cnt_ff, cnt_in;
   logic [rprm_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [rprm_pkg::CPM_W-1:0]   icpm_ff, icpm_in;
   logic                         ivalid_ff, ivalid_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [rprm_pkg::ROLL_W-1:0]  rsp_rolling_ff, rsp_rolling_in;
   logic [rprm_pkg::CPM_W-1:0]   rsp_icpm_ff, rsp_icpm_in;
   logic                         rsp_ivalid_ff, rsp_ivalid_in;
   logic [rprm_pkg::DOSE_W-1:0]  rsp_dose_ff, rsp_dose_in;

   logic                          req_accept;
   logic                          bin_write;
   logic [rprm_pkg::TIME_W-1:0]   interval_now;
   logic [rprm_pkg::MEAN_W:0]     rem_shift;
   logic [rprm_pkg::MEAN_W+1:0]   rem_diff;
   logic                          q_bit;
   logic [rprm_pkg::DIV_W-1:0]    q_next;
   logic [rprm_pkg::FACTOR_W:0]   mul_sum;
   logic [rprm_pkg::MUL_W-1:0]    sum_wide;
   logic [rprm_pkg::MUL_W-1:0]    mul_count;
   logic                          out_free;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign bin_write  = req_accept && (req_func == rprm_pkg::FUNC_TICK);
   assign interval_now = req_timestamp - last_time_ff;
   assign sum_wide  = rprm_pkg::MUL_W'(window_sum_ff);
   assign mul_count = use_rolling_ff ? sum_wide : icpm_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // divider step: shift in one dividend bit, try to subtract the divisor
   assign rem_shift = {div_rem_ff, div_q_ff[rprm_pkg::DIV_W-1]};
   assign rem_diff  = {1'b0, rem_shift} - {2'b00, div_den_ff};
   assign q_bit     = !rem_diff[rprm_pkg::MEAN_W+1];
   assign q_next    = {div_q_ff[rprm_pkg::DIV_W-2:0], q_bit};

   // multiplier step: add the factor when the low multiplier bit is set
   assign mul_sum = {1'b0, prod_ff[rprm_pkg::PROD_W-1:rprm_pkg::MUL_W]}
                  + (prod_ff[0] ? {1'b0, dose_factor_ff} : '0);

   // sequencer and datapath next state
   always_comb begin
      state_in       = state_ff;
      last_time_in   = last_time_ff;
      seen_pulse_in  = seen_pulse_ff;
      interval_in    = interval_ff;
      mean_in        = mean_ff;
      mean_valid_in  = mean_valid_ff;
      pending_in     = pending_ff;
      slot_in        = slot_ff;
      window_sum_in  = window_sum_ff;
      div_q_in       = div_q_ff;
      div_rem_in     = div_rem_ff;
      div_den_in     = div_den_ff;
      div_rate_in    = div_rate_ff;
      cnt_in         = cnt_ff;
      prod_in        = prod_ff;
      icpm_in        = icpm_ff;
      ivalid_in      = ivalid_ff;
      rsp_rolling_in = rsp_rolling_ff;
      rsp_icpm_in    = rsp_icpm_ff;
      rsp_ivalid_in  = rsp_ivalid_ff;
      rsp_dose_in    = rsp_dose_ff;

      // output register drains when taken
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               unique case (req_func)
                  rprm_pkg::FUNC_PULSE: begin
                     if (pending_ff != '1) begin
                        pending_in = pending_ff + 1'b1;
                     end
                     if (seen_pulse_ff) begin
                        interval_in = interval_now;
                        if (!mean_valid_ff) begin
                           mean_in       = {interval_now, 8'h00};
                           mean_valid_in = 1'b1;
                        end else begin
                           state_in = S_MEAN9;
                        end
                     end
                     last_time_in  = req_timestamp;
                     seen_pulse_in = 1'b1;
                  end
                  rprm_pkg::FUNC_TICK: begin
                     window_sum_in = window_sum_ff + SUM_W'(pending_ff)
                                   - SUM_W'(bins_ff[slot_ff]);
                     slot_in       = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
                     pending_in    = '0;
                  end
                  rprm_pkg::FUNC_REPORT: begin
                     ivalid_in = mean_valid_ff && (mean_ff != '0);
                     if (mean_valid_ff && (mean_ff != '0)) begin
                        div_q_in    = {rprm_pkg::RATE_NUM,
                                       (rprm_pkg::DIV_W-rprm_pkg::RATE_W)'(0)};
                        div_rem_in  = '0;
                        div_den_in  = mean_ff;
                        div_rate_in = 1'b1;
                        cnt_in      = rprm_pkg::DIV_STEPS_RATE;
                        state_in    = S_DIV;
                     end else begin
                        icpm_in  = '0;
                        state_in = S_MLOAD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_MEAN9: begin
            div_q_in = rprm_pkg::DIV_W'({mean_ff, 3'b000}) + rprm_pkg::DIV_W'(mean_ff);
            state_in = S_MEANADD;
         end
         S_MEANADD: begin
            // x + 5 with x = interval in q32.8 has its rounding in the low byte
            div_q_in    = div_q_ff
                        + rprm_pkg::DIV_W'({interval_ff, rprm_pkg::MEAN_ROUND});
            div_rem_in  = '0;
            div_den_in  = rprm_pkg::MEAN_DIVISOR;
            div_rate_in = 1'b0;
            cnt_in      = rprm_pkg::DIV_STEPS_MEAN;
            state_in    = S_DIV;
         end
         S_DIV: begin
            div_q_in   = q_next;
            div_rem_in = q_bit ? rem_diff[rprm_pkg::MEAN_W-1:0]
                               : rem_shift[rprm_pkg::MEAN_W-1:0];
            cnt_in     = cnt_ff - 1'b1;
            if (cnt_ff == rprm_pkg::STEP_W'(1)) begin
               if (div_rate_ff) begin
                  icpm_in  = (q_next[rprm_pkg::RATE_W-1:rprm_pkg::CPM_W] != '0) ?
                             '1 : q_next[rprm_pkg::CPM_W-1:0];
                  state_in = S_MLOAD;
               end else begin
                  mean_in  = q_next[rprm_pkg::MEAN_W-1:0];
                  state_in = S_IDLE;
               end
            end
         end
         S_MLOAD: begin
            prod_in  = {rprm_pkg::FACTOR_W'(0), mul_count};
            cnt_in   = rprm_pkg::MUL_STEPS;
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in = {mul_sum, prod_ff[rprm_pkg::MUL_W-1:1]};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == rprm_pkg::STEP_W'(1)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_rolling_in = (sum_wide > ROLL_MAX) ? '1
                                                      : sum_wide[rprm_pkg::ROLL_W-1:0];
               rsp_icpm_in    = icpm_ff;
               rsp_ivalid_in  = ivalid_ff;
               // product >> 8, saturated to 32 bits
               rsp_dose_in    = (prod_ff[rprm_pkg::PROD_W-1:rprm_pkg::DOSE_W+8] != '0) ?
                                '1 : prod_ff[rprm_pkg::DOSE_W+7:8];
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         last_time_ff  <= '0;
         seen_pulse_ff <= 1'b0;
         mean_ff       <= '0;
         mean_valid_ff <= 1'b0;
         pending_ff    <= '0;
         slot_ff       <= '0;
         window_sum_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_time_ff  <= last_time_in;
         seen_pulse_ff <= seen_pulse_in;
         mean_ff       <= mean_in;
         mean_valid_ff <= mean_valid_in;
         pending_ff    <= pending_in;
         slot_ff       <= slot_in;
         window_sum_ff <= window_sum_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      interval_ff    <= interval_in;
      div_q_ff       <= div_q_in;
      div_rem_ff     <= div_rem_in;
      div_den_ff     <= div_den_in;
      div_rate_ff    <= div_rate_in;
      cnt_ff         <= cnt_in;
      prod_ff        <= prod_in;
      icpm_ff        <= icpm_in;
      ivalid_ff      <= ivalid_in;
      rsp_rolling_ff <= rsp_rolling_in;
      rsp_icpm_ff    <= rsp_icpm_in;
      rsp_ivalid_ff  <= rsp_ivalid_in;
      rsp_dose_ff    <= rsp_dose_in;
   end

   // bin store, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BINS; i++) begin
            bins_ff[i] <= '0;
         end
      end else if (bin_write) begin
         bins_ff[slot_ff] <= pending_ff;
      end
   end

   // configuration registers, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         dose_factor_ff <= rprm_pkg::DOSE_FACTOR_RESET;
         use_rolling_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            rprm_pkg::CSR_DOSE_FACTOR: begin
               dose_factor_ff <= csr_data;
            end
            rprm_pkg::CSR_USE_ROLLING: begin
               use_rolling_ff <= csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_rolling_cpm   = rsp_rolling_ff;
   assign rsp_instant_cpm   = rsp_icpm_ff;
   assign rsp_instant_valid = rsp_ivalid_ff;
   assign rsp_dose_rate     = rsp_dose_ff;

endmodule

// ===== rtl/core/rprm_checker.sv =====
// port-level checks of the rate meter and their binding to the top level
module rprm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [rprm_pkg::FUNC_W-1:0]   req_func,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [rprm_pkg::ROLL_W-1:0]   rsp_rolling_cpm,
   input logic [rprm_pkg::CPM_W-1:0]    rsp_instant_cpm,
   input logic                          rsp_instant_valid,
   input logic [rprm_pkg::DOSE_W-1:0]   rsp_dose_rate
);

   // a stalled result item stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   // a stalled result item keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_rolling_cpm) && $stable(rsp_instant_cpm)
         && $stable(rsp_instant_valid) && $stable(rsp_dose_rate))
      else $error("rsp payload changed while stalled");

   // no mean means no instantaneous rate
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_instant_valid |-> rsp_instant_cpm == '0)
      else $error("instant rate without a mean");

   // a report occupies the block for the division and multiply
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_func == rprm_pkg::FUNC_REPORT |=> req_stall)
      else $error("report item did not start the sequencer");

   // reset empties the output register
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind radiation_pulse_rate_meter_unit rprm_checker u_rprm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_func          (req_func),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_rolling_cpm   (rsp_rolling_cpm),
   .rsp_instant_cpm   (rsp_instant_cpm),
   .rsp_instant_valid (rsp_instant_valid),
   .rsp_dose_rate     (rsp_dose_rate)
);

// ===== sim/testbench.sv =====
// self-checking testbench for the radiation pulse rate meter unit
module testbench;

   localparam int unsigned NUM_BINS = 6;
   localparam logic [rprm_pkg::FUNC_W-1:0]      FUNC_UNUSED = 2'd3;
   localparam logic [rprm_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [rprm_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HI = 2'd3;
   localparam int unsigned MAX_PRINTED = 64;

   // expected reports and a bit-true copy of the meter state
   class dose_report_board;
      typedef struct {
         logic [rprm_pkg::ROLL_W-1:0] rolling_cpm;
         logic [rprm_pkg::CPM_W-1:0]  instant_cpm;
         logic                        instant_valid;
         logic [rprm_pkg::DOSE_W-1:0] dose_rate;
      } report_type;

      localparam logic [63:0] CPM_SCALE_Q8 = 64'd15360000000;
      localparam logic [63:0] SAT32 = 64'hFFFF_FFFF;
      localparam logic [rprm_pkg::COUNT_W-1:0] COUNT_FULL = {rprm_pkg::COUNT_W{1'b1}};
      localparam logic [rprm_pkg::ROLL_W-1:0]  ROLL_MAX = {rprm_pkg::ROLL_W{1'b1}};

      report_type expected_reports[$];
      int unsigned mismatches;

      logic [rprm_pkg::FACTOR_W-1:0] dose_factor;
      logic                          use_rolling;
      logic [rprm_pkg::TIME_W-1:0]   last_time;
      logic                          seen_pulse;
      logic [rprm_pkg::MEAN_W-1:0]   mean_interval;
      logic                          mean_valid;
      logic [rprm_pkg::COUNT_W-1:0]  pending_count;
      logic [rprm_pkg::COUNT_W-1:0]  bin_counts[NUM_BINS];
      int unsigned                   bin_slot;
      logic [63:0]                   window_sum;

      function new();
         dose_factor   = rprm_pkg::DOSE_FACTOR_RESET;
         use_rolling   = 1'b0;
         last_time     = '0;
         seen_pulse    = 1'b0;
         mean_interval = '0;
         mean_valid    = 1'b0;
         pending_count = '0;
         foreach (bin_counts[i]) bin_counts[i] = '0;
         bin_slot      = 0;
         window_sum    = '0;
         mismatches    = 0;
      endfunction

      function int unsigned outstanding();
         return expected_reports.size();
      endfunction

      function void write_reg(logic [rprm_pkg::CSR_INDEX_W-1:0] index,
                              logic [rprm_pkg::FACTOR_W-1:0] data);
         case (index)
            rprm_pkg::CSR_DOSE_FACTOR: dose_factor = data;
            rprm_pkg::CSR_USE_ROLLING: use_rolling = data[0];
            default: ;
         endcase
      endfunction

      // pulse: count it, then filter the wrapped interval into the mean
      function void count_pulse(logic [rprm_pkg::TIME_W-1:0] stamp);
         logic [rprm_pkg::TIME_W-1:0] gap_us;
         logic [rprm_pkg::MEAN_W-1:0] sample;
         logic [63:0]                 acc;
         if (pending_count != COUNT_FULL) pending_count = pending_count + 1'b1;
         if (seen_pulse) begin
            gap_us = stamp - last_time;
            sample = {gap_us, 8'd0};
            if (!mean_valid) begin
               mean_interval = sample;
               mean_valid    = 1'b1;
            end else begin
               acc = 64'(mean_interval) * 64'd9 + 64'(sample) + 64'd5;
               mean_interval = rprm_pkg::MEAN_W'(acc / 64'd10);
            end
         end
         last_time  = stamp;
         seen_pulse = 1'b1;
      endfunction

      // tick: retire the oldest bin and slide the window
      function void close_bin();
         if (bin_slot >= NUM_BINS) bin_slot = 0;
         window_sum = window_sum + 64'(pending_count) - 64'(bin_counts[bin_slot]);
         bin_counts[bin_slot] = pending_count;
         bin_slot = bin_slot + 1;
         if (bin_slot >= NUM_BINS) bin_slot = 0;
         pending_count = '0;
      endfunction

      function report_type predict_report();
         report_type  r;
         logic [63:0] rate;
         logic [63:0] dose;
         logic        has_rate;
         has_rate = mean_valid && (mean_interval != '0);
         rate = has_rate ? CPM_SCALE_Q8 / 64'(mean_interval) : 64'd0;
         if (rate > SAT32) rate = SAT32;
         dose = (64'(dose_factor) * (use_rolling ? window_sum : rate)) >> 8;
         if (dose > SAT32) dose = SAT32;
         r.rolling_cpm   = (window_sum > 64'(ROLL_MAX)) ? ROLL_MAX
                                                        : rprm_pkg::ROLL_W'(window_sum);
         r.instant_cpm   = rprm_pkg::CPM_W'(rate);
         r.instant_valid = has_rate;
         r.dose_rate     = rprm_pkg::DOSE_W'(dose);
         return r;
      endfunction

      // accepted input item
      function void take_item(logic [rprm_pkg::FUNC_W-1:0] func,
                              logic [rprm_pkg::TIME_W-1:0] stamp);
         case (func)
            rprm_pkg::FUNC_PULSE:  count_pulse(stamp);
            rprm_pkg::FUNC_TICK:   close_bin();
            rprm_pkg::FUNC_REPORT: expected_reports.push_back(predict_report());
            default: ;
         endcase
      endfunction

      task report_mismatch(string what);
         if (mismatches < MAX_PRINTED) $display("mismatch: %s", what);
         mismatches++;
      endtask

      // accepted result item against the oldest expectation
      task check_report(logic [rprm_pkg::ROLL_W-1:0] rolling,
                        logic [rprm_pkg::CPM_W-1:0] icpm,
                        logic ivalid, logic [rprm_pkg::DOSE_W-1:0] dose);
         report_type want;
         if (expected_reports.size() == 0) begin
            report_mismatch("report item with none expected");
            return;
         end
         want = expected_reports.pop_front();
         if (rolling !== want.rolling_cpm)
            report_mismatch($sformatf("rolling_cpm %0d, expected %0d", rolling,
                                      want.rolling_cpm));
         if (icpm !== want.instant_cpm)
            report_mismatch($sformatf("instant_cpm %0d, expected %0d", icpm,
                                      want.instant_cpm));
         if (ivalid !== want.instant_valid)
            report_mismatch($sformatf("instant_valid %0b, expected %0b", ivalid,
                                      want.instant_valid));
         if (dose !== want.dose_rate)
            report_mismatch($sformatf("dose_rate %0d, expected %0d", dose,
                                      want.dose_rate));
      endtask
   endclass

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic [rprm_pkg::FUNC_W-1:0]      req_func;
   logic [rprm_pkg::TIME_W-1:0]      req_timestamp;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic [rprm_pkg::ROLL_W-1:0]      rsp_rolling_cpm;
   logic [rprm_pkg::CPM_W-1:0]       rsp_instant_cpm;
   logic                             rsp_instant_valid;
   logic [rprm_pkg::DOSE_W-1:0]      rsp_dose_rate;
   logic                             csr_write;
   logic [rprm_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [rprm_pkg::FACTOR_W-1:0]    csr_data;

   dose_report_board            board;
   bit                          idle_on;
   bit                          rsp_hold;
   logic [rprm_pkg::TIME_W-1:0] now_us;

   radiation_pulse_rate_meter_unit #(.NUM_BINS(NUM_BINS)) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_timestamp     (req_timestamp),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_rolling_cpm   (rsp_rolling_cpm),
      .rsp_instant_cpm   (rsp_instant_cpm),
      .rsp_instant_valid (rsp_instant_valid),
      .rsp_dose_rate     (rsp_dose_rate),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // result sampling
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         board.check_report(rsp_rolling_cpm, rsp_instant_cpm, rsp_instant_valid,
                            rsp_dose_rate);
   end

   // result side: random stall before each item while idle_on is set, long hold on request
   initial begin : rsp_side
      int unsigned pause;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         pause = idle_on ? $urandom_range(0, 6) : 0;
         if (pause != 0) begin
            rsp_stall <= 1'b1;
            repeat (pause) @(negedge clock);
         end
         if (rsp_hold) begin
            rsp_stall <= 1'b1;
            while (rsp_hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         @(negedge clock);
      end
   end

   // offer one item, after a random gap while idle_on is set, and wait until it is taken
   task automatic send_item(input logic [rprm_pkg::FUNC_W-1:0] func,
                            input logic [rprm_pkg::TIME_W-1:0] stamp);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= func;
      req_timestamp <= stamp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.take_item(func, stamp);
      @(negedge clock);
   endtask

   task automatic csr_put(input logic [rprm_pkg::CSR_INDEX_W-1:0] index,
                          input logic [rprm_pkg::FACTOR_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      board.write_reg(index, data);
      @(negedge clock);
   endtask

   // register setup, only between phases; stray bits above bit 0 must be ignored
   task automatic program_meter(input logic [rprm_pkg::FACTOR_W-1:0] factor,
                                input logic rolling, input bit spare_too);
      csr_put(rprm_pkg::CSR_DOSE_FACTOR, factor);
      csr_put(rprm_pkg::CSR_USE_ROLLING,
              (rprm_pkg::FACTOR_W'($urandom) & ~rprm_pkg::FACTOR_W'(1))
              | rprm_pkg::FACTOR_W'(rolling));
      if (spare_too) begin
         csr_put(CSR_SPARE_LO, rprm_pkg::FACTOR_W'($urandom));
         csr_put(CSR_SPARE_HI, rprm_pkg::FACTOR_W'($urandom));
      end
      csr_write <= 1'b0;
   endtask

   // drop valid, wait for every report, then let a long pulse finish
   task automatic settle_block();
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      @(negedge clock);
   endtask

   // mostly steady detector timing, with repeats, wide jumps and noise
   function automatic logic [rprm_pkg::TIME_W-1:0] next_stamp();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 80)      now_us = now_us + $urandom_range(1, 3000);
      else if (pick < 88) now_us = now_us;
      else if (pick < 94) now_us = now_us + $urandom;
      else                now_us = $urandom;
      return now_us;
   endfunction

   task automatic run_random(input int unsigned count);
      int unsigned pick;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 50)      send_item(rprm_pkg::FUNC_PULSE, next_stamp());
         else if (pick < 70) send_item(rprm_pkg::FUNC_TICK, $urandom);
         else if (pick < 96) send_item(rprm_pkg::FUNC_REPORT, $urandom);
         else                send_item(FUNC_UNUSED, $urandom);
      end
   endtask

   // corner cases: no mean, zero mean, wrapped and widest intervals, window wrap
   task automatic run_directed();
      send_item(rprm_pkg::FUNC_REPORT, 32'h0000_0000);
      send_item(FUNC_UNUSED, 32'hFFFF_FFFF);
      send_item(rprm_pkg::FUNC_TICK, 32'hFFFF_FFFF);
      send_item(rprm_pkg::FUNC_PULSE, 32'hFFFF_FFF0);
      send_item(rprm_pkg::FUNC_PULSE, 32'hFFFF_FFF0);
      send_item(rprm_pkg::FUNC_REPORT, 32'hFFFF_FFFF);
      send_item(rprm_pkg::FUNC_PULSE, 32'hFFFF_FFF1);
      send_item(rprm_pkg::FUNC_REPORT, 32'h0000_0000);
      send_item(rprm_pkg::FUNC_PULSE, 32'h0000_0010);
      send_item(rprm_pkg::FUNC_TICK, 32'h0000_0000);
      send_item(rprm_pkg::FUNC_REPORT, 32'h5555_5555);
      send_item(rprm_pkg::FUNC_PULSE, 32'h0000_000F);
      send_item(rprm_pkg::FUNC_REPORT, 32'hAAAA_AAAA);
      for (int i = 0; i < 7; i++) begin
         if (i[0]) send_item(rprm_pkg::FUNC_PULSE, 32'h0000_0010 + 32'(i));
         send_item(rprm_pkg::FUNC_TICK, 32'h0000_0000);
      end
      send_item(FUNC_UNUSED, 32'h0000_0000);
      send_item(rprm_pkg::FUNC_REPORT, 32'h0000_0000);
      now_us = 32'h0000_0013;
   endtask

   initial begin
      board         = new();
      idle_on       = 1'b1;
      rsp_hold      = 1'b0;
      now_us        = '0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_func      = rprm_pkg::FUNC_PULSE;
      req_timestamp = '0;
      csr_write     = 1'b0;
      csr_index     = rprm_pkg::CSR_DOSE_FACTOR;
      csr_data      = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset register values
      run_directed();
      run_random(150);

      settle_block();
      program_meter({rprm_pkg::FACTOR_W{1'b1}}, 1'b0, 1'b0);
      idle_on = 1'b0;
      run_random(150);

      // receiver holds off so the block backs up into its input
      settle_block();
      program_meter({rprm_pkg::FACTOR_W{1'b1}}, 1'b1, 1'b0);
      idle_on = 1'b1;
      fork
         begin
            @(posedge clock);
            rsp_hold = 1'b1;
            repeat (400) @(posedge clock);
            rsp_hold = 1'b0;
         end
      join_none
      run_random(150);

      settle_block();
      program_meter('0, 1'b1, 1'b1);
      run_random(120);

      settle_block();
      program_meter('0, 1'b0, 1'b0);
      idle_on = 1'b0;
      run_random(100);

      settle_block();
      program_meter(rprm_pkg::FACTOR_W'($urandom), 1'($urandom), 1'b1);
      idle_on = 1'b1;
      run_random(150);

      settle_block();
      program_meter(rprm_pkg::FACTOR_W'($urandom), 1'b1, 1'b0);
      run_random(100);

      settle_block();
      repeat (100) @(posedge clock);
      if (board.mismatches == 0 && board.outstanding() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/rprm_pkg.sv
rtl/core/radiation_pulse_rate_meter_unit.sv
rtl/core/rprm_checker.sv
sim/testbench.sv
